[rtl/polygon_clip_to_unit_window_core_defines.svh]
// Assertion macros shared by the polygon clipper RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef POLYGON_CLIP_TO_UNIT_WINDOW_CORE_DEFINES_SVH
`define POLYGON_CLIP_TO_UNIT_WINDOW_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PCUW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcuw assertion failed");
`define PCUW_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pcuw forbidden condition seen");
`else
`define PCUW_ASSERT(lbl, clk, rst, prop)
`define PCUW_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/pcuw_pkg.sv]
// Types, constants and helpers of the unit window polygon clipper.
// Used by every module of the block; depends on nothing.
package pcuw_pkg;

   localparam int CW = 24;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int MAX_VERTICES = 16;
   localparam int DEPTH = MAX_VERTICES + 4;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int STEP_W = $clog2(DW);
   localparam logic signed [CW-1:0] WIN_ONE = CW'(65536);
   localparam logic signed [CW-1:0] WIN_NEG = -WIN_ONE;

   localparam logic [1:0] STG_LEFT = 2'd0;
   localparam logic [1:0] STG_BOTTOM = 2'd1;
   localparam logic [1:0] STG_RIGHT = 2'd2;
   localparam logic [1:0] STG_TOP = 2'd3;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } vertex_type;

   typedef struct packed {
      logic signed [CW-1:0] vertex_x;
      logic signed [CW-1:0] vertex_y;
      logic last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] out_x;
      logic signed [CW-1:0] out_y;
      logic last_out;
      logic empty_res;
      logic overflow;
   } rsp_type;

   typedef struct packed {
      vertex_type v;
      logic last;
      logic keep;
   } fitem_type;

   typedef struct packed {
      logic start;
      logic [DW-1:0] a;
      logic [DW-1:0] d;
      logic [DW-1:0] c;
   } md_req_type;

   typedef struct packed {
      logic done;
      logic [DW-1:0] q;
   } md_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_SREAD, ST_EVAL, ST_MUL, ST_DIV,
      ST_APPEND, ST_NEXT, ST_END, ST_ORD, ST_OPUSH
   } state_type;

   function automatic logic in_window(logic [1:0] stage, vertex_type v);
      logic r;
      case (stage)
         STG_LEFT: r = (v.x >= WIN_NEG);
         STG_BOTTOM: r = (v.y >= WIN_NEG);
         STG_RIGHT: r = (v.x <= WIN_ONE);
         STG_TOP: r = (v.y <= WIN_ONE);
         default: r = 1'b1;
      endcase
      return r;
   endfunction

   function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

endpackage

[rtl/pcuw_front.sv]
// Front end: accepts vertex beats into a four entry queue and marks
// each as kept or dropped against the vertex capacity. Uses pcuw_pkg.
module pcuw_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  pcuw_pkg::req_type req_data,
   input  logic deq_pop,
   output logic deq_valid,
   output pcuw_pkg::fitem_type deq_item
);
   pcuw_pkg::fitem_type q_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [pcuw_pkg::CNT_W-1:0] seen_ff, seen_in;
   logic push, pop, keep;

   assign req_full = (cnt_ff == 3'd4);
   assign deq_valid = (cnt_ff != 3'd0);
   assign deq_item = q_ff[rd_ff];
   assign push = req_push && !req_full;
   assign pop = deq_pop && deq_valid;
   assign keep = (seen_ff < pcuw_pkg::CNT_W'(pcuw_pkg::MAX_VERTICES));

   always_comb begin
      wr_in = push ? wr_ff + 2'd1 : wr_ff;
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
      seen_in = seen_ff;
      if (push) begin
         if (req_data.last_vertex) begin
            seen_in = '0;
         end else if (keep) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         seen_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{v: '{x: req_data.vertex_x, y: req_data.vertex_y},
                          last: req_data.last_vertex, keep: keep};
      end
   end
endmodule

[rtl/pcuw_muldiv.sv]
// Crossing point arithmetic: floor(a * d / c) on magnitudes, a registered
// multiply step then one quotient bit per cycle. Uses pcuw_pkg.
module pcuw_muldiv (
   input  logic clock,
   input  logic reset,
   input  pcuw_pkg::md_req_type md_req,
   output pcuw_pkg::md_rsp_type md_rsp
);
   logic busy_ff, mul_ff, done_ff;
   logic [pcuw_pkg::STEP_W-1:0] step_ff;
   logic [pcuw_pkg::DW-1:0] a_ff, d_ff, c_ff, rem_ff, qsh_ff, rem_in;
   logic [pcuw_pkg::PW-1:0] prod;
   logic [pcuw_pkg::DW:0] trial, diff;
   logic ge;

   assign prod = a_ff * d_ff;
   assign trial = {rem_ff, qsh_ff[pcuw_pkg::DW-1]};
   assign diff = trial - {1'b0, c_ff};
   assign ge = (trial >= {1'b0, c_ff});
   assign rem_in = ge ? diff[pcuw_pkg::DW-1:0] : trial[pcuw_pkg::DW-1:0];
   assign md_rsp = '{done: done_ff, q: qsh_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (md_req.start) begin
            busy_ff <= 1'b1;
            mul_ff <= 1'b1;
         end else if (busy_ff && mul_ff) begin
            mul_ff <= 1'b0;
         end else if (busy_ff && step_ff == pcuw_pkg::STEP_W'(pcuw_pkg::DW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // The high half of the product is already below the divisor because
   // the quotient never exceeds |d|, so only the low half is shifted in.
   always_ff @(posedge clock) begin
      if (md_req.start) begin
         a_ff <= md_req.a;
         d_ff <= md_req.d;
         c_ff <= md_req.c;
      end else if (busy_ff && mul_ff) begin
         rem_ff <= prod[pcuw_pkg::PW-1:pcuw_pkg::DW];
         qsh_ff <= prod[pcuw_pkg::DW-1:0];
         step_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         qsh_ff <= {qsh_ff[pcuw_pkg::DW-2:0], ge};
         step_ff <= step_ff + 1'b1;
      end
   end
endmodule

[rtl/pcuw_rspq.sv]
// Two entry result queue between the clip engine and the result port.
// Uses pcuw_pkg for the result beat type.
module pcuw_rspq (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  pcuw_pkg::rsp_type push_data,
   input  logic pop,
   output logic empty,
   output pcuw_pkg::rsp_type pop_data
);
   pcuw_pkg::rsp_type q_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic do_push, do_pop;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_data = q_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_ff ^ do_push;
         rd_ff <= rd_ff ^ do_pop;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= push_data;
      end
   end
endmodule

[rtl/pcuw_back.sv]
// Clip engine: stores kept vertices, runs the four window stages over
// two ping-pong vertex memories and emits result beats. Uses pcuw_pkg.
`include "polygon_clip_to_unit_window_core_defines.svh"
module pcuw_back (
   input  logic clock,
   input  logic reset,
   input  logic deq_valid,
   input  pcuw_pkg::fitem_type deq_item,
   output logic deq_pop,
   output logic rsp_push,
   input  logic rsp_full,
   output pcuw_pkg::rsp_type rsp_data
);
   pcuw_pkg::state_type state_ff, state_in;
   pcuw_pkg::vertex_type mem0 [pcuw_pkg::DEPTH];
   pcuw_pkg::vertex_type mem1 [pcuw_pkg::DEPTH];
   pcuw_pkg::vertex_type rd0_ff, rd1_ff, rdv;
   pcuw_pkg::vertex_type s_ff, s_in, e_ff, e_in, v2_ff, v2_in, wr_v, app_v, cross_v;
   logic bank_ff, bank_in, ovf_ff, ovf_in, neg_ff, neg_in;
   logic [1:0] stage_ff, stage_in;
   logic [pcuw_pkg::CNT_W-1:0] n_ff, n_in, nb_ff, nb_in;
   logic [pcuw_pkg::ADDR_W-1:0] j_ff, j_in, wr_addr, rd_addr;
   logic signed [pcuw_pkg::CW-1:0] x0_ff, x0_in, x1_ff, x1_in, base_ff, base_in, bnd;
   logic signed [pcuw_pkg::DW-1:0] da, dd, dc;
   logic signed [pcuw_pkg::DW:0] sq, csum;
   logic wr_en, wr_bank, rd_en, app_en, e_inside, s_inside, j_last;
   pcuw_pkg::md_req_type md_req;
   pcuw_pkg::md_rsp_type md_rsp;

   pcuw_muldiv u_muldiv (
      .clock(clock), .reset(reset), .md_req(md_req), .md_rsp(md_rsp)
   );

   assign rdv = bank_ff ? rd1_ff : rd0_ff;
   assign bnd = stage_ff[1] ? pcuw_pkg::WIN_ONE : pcuw_pkg::WIN_NEG;
   assign s_inside = pcuw_pkg::in_window(stage_ff, s_ff);
   assign e_inside = pcuw_pkg::in_window(stage_ff, e_ff);
   assign j_last = (pcuw_pkg::CNT_W'(j_ff) + 1'b1 == n_ff);

   // Left and right edges are vertical: the crossing keeps x at the edge.
   always_comb begin
      if (!stage_ff[0]) begin
         da = {bnd[pcuw_pkg::CW-1], bnd} - {s_ff.x[pcuw_pkg::CW-1], s_ff.x};
         dd = {e_ff.y[pcuw_pkg::CW-1], e_ff.y} - {s_ff.y[pcuw_pkg::CW-1], s_ff.y};
         dc = {e_ff.x[pcuw_pkg::CW-1], e_ff.x} - {s_ff.x[pcuw_pkg::CW-1], s_ff.x};
         base_in = s_ff.y;
      end else begin
         da = {bnd[pcuw_pkg::CW-1], bnd} - {s_ff.y[pcuw_pkg::CW-1], s_ff.y};
         dd = {e_ff.x[pcuw_pkg::CW-1], e_ff.x} - {s_ff.x[pcuw_pkg::CW-1], s_ff.x};
         dc = {e_ff.y[pcuw_pkg::CW-1], e_ff.y} - {s_ff.y[pcuw_pkg::CW-1], s_ff.y};
         base_in = s_ff.x;
      end
      neg_in = da[pcuw_pkg::DW-1] ^ dd[pcuw_pkg::DW-1] ^ dc[pcuw_pkg::DW-1];
      sq = neg_ff ? -$signed({1'b0, md_rsp.q}) : $signed({1'b0, md_rsp.q});
      csum = {{2{base_ff[pcuw_pkg::CW-1]}}, base_ff} + sq;
      if (!stage_ff[0]) begin
         cross_v = '{x: bnd, y: csum[pcuw_pkg::CW-1:0]};
      end else begin
         cross_v = '{x: csum[pcuw_pkg::CW-1:0], y: bnd};
      end
   end

   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      ovf_in = ovf_ff;
      stage_in = stage_ff;
      n_in = n_ff;
      nb_in = nb_ff;
      j_in = j_ff;
      s_in = s_ff;
      e_in = e_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      v2_in = v2_ff;
      wr_en = 1'b0;
      wr_bank = bank_ff;
      wr_addr = '0;
      wr_v = deq_item.v;
      rd_en = 1'b0;
      rd_addr = '0;
      app_en = 1'b0;
      app_v = e_ff;
      deq_pop = 1'b0;
      rsp_push = 1'b0;
      md_req = '{start: 1'b0, a: pcuw_pkg::mag(da), d: pcuw_pkg::mag(dd),
                 c: pcuw_pkg::mag(dc)};
      rsp_data = '{out_x: rdv.x, out_y: rdv.y, last_out: j_last, empty_res: 1'b0,
                   overflow: ovf_ff};
      case (state_ff)
         pcuw_pkg::ST_IDLE: begin
            if (deq_valid) begin
               deq_pop = 1'b1;
               if (deq_item.keep) begin
                  wr_en = 1'b1;
                  wr_addr = n_ff[pcuw_pkg::ADDR_W-1:0];
                  n_in = n_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (deq_item.last) begin
                  stage_in = pcuw_pkg::STG_LEFT;
                  state_in = pcuw_pkg::ST_START;
               end
            end
         end
         pcuw_pkg::ST_START: begin
            nb_in = '0;
            if (n_ff == '0) begin
               state_in = pcuw_pkg::ST_END;
            end else begin
               rd_en = 1'b1;
               rd_addr = pcuw_pkg::ADDR_W'(n_ff - 1'b1);
               state_in = pcuw_pkg::ST_SREAD;
            end
         end
         pcuw_pkg::ST_SREAD: begin
            s_in = rdv;
            j_in = '0;
            rd_en = 1'b1;
            state_in = pcuw_pkg::ST_EVAL;
         end
         pcuw_pkg::ST_EVAL: begin
            e_in = rdv;
            if (pcuw_pkg::in_window(stage_ff, rdv) != s_inside) begin
               state_in = pcuw_pkg::ST_MUL;
            end else if (s_inside) begin
               state_in = pcuw_pkg::ST_APPEND;
            end else begin
               state_in = pcuw_pkg::ST_NEXT;
            end
         end
         pcuw_pkg::ST_MUL: begin
            md_req.start = 1'b1;
            state_in = pcuw_pkg::ST_DIV;
         end
         pcuw_pkg::ST_DIV: begin
            if (md_rsp.done) begin
               app_en = 1'b1;
               app_v = cross_v;
               state_in = e_inside ? pcuw_pkg::ST_APPEND : pcuw_pkg::ST_NEXT;
            end
         end
         pcuw_pkg::ST_APPEND: begin
            app_en = 1'b1;
            state_in = pcuw_pkg::ST_NEXT;
         end
         pcuw_pkg::ST_NEXT: begin
            s_in = e_ff;
            if (j_last) begin
               state_in = pcuw_pkg::ST_END;
            end else begin
               j_in = j_ff + 1'b1;
               rd_en = 1'b1;
               rd_addr = j_ff + 1'b1;
               state_in = pcuw_pkg::ST_EVAL;
            end
         end
         pcuw_pkg::ST_END: begin
            // A two vertex line that grew to three keeps its first vertex
            // and one of the other two, chosen by the first two x values.
            if (n_ff == pcuw_pkg::CNT_W'(2) && nb_ff == pcuw_pkg::CNT_W'(3)) begin
               n_in = pcuw_pkg::CNT_W'(2);
               if (x0_ff == x1_ff) begin
                  wr_en = 1'b1;
                  wr_bank = !bank_ff;
                  wr_addr = pcuw_pkg::ADDR_W'(1);
                  wr_v = v2_ff;
               end
            end else begin
               n_in = nb_ff;
            end
            bank_in = !bank_ff;
            j_in = '0;
            if (stage_ff == pcuw_pkg::STG_TOP) begin
               state_in = pcuw_pkg::ST_ORD;
            end else begin
               stage_in = stage_ff + 1'b1;
               state_in = pcuw_pkg::ST_START;
            end
         end
         pcuw_pkg::ST_ORD: begin
            rd_en = 1'b1;
            rd_addr = j_ff;
            state_in = pcuw_pkg::ST_OPUSH;
         end
         pcuw_pkg::ST_OPUSH: begin
            if (n_ff == '0) begin
               rsp_data = '{out_x: '0, out_y: '0, last_out: 1'b1, empty_res: 1'b1,
                            overflow: ovf_ff};
            end
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (n_ff == '0 || j_last) begin
                  n_in = '0;
                  nb_in = '0;
                  ovf_in = 1'b0;
                  state_in = pcuw_pkg::ST_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = pcuw_pkg::ST_ORD;
               end
            end
         end
         default: begin
            state_in = pcuw_pkg::ST_IDLE;
         end
      endcase
      if (app_en) begin
         if (nb_ff < pcuw_pkg::CNT_W'(pcuw_pkg::DEPTH)) begin
            wr_en = 1'b1;
            wr_bank = !bank_ff;
            wr_addr = nb_ff[pcuw_pkg::ADDR_W-1:0];
            wr_v = app_v;
            nb_in = nb_ff + 1'b1;
            if (nb_ff == pcuw_pkg::CNT_W'(0)) x0_in = app_v.x;
            if (nb_ff == pcuw_pkg::CNT_W'(1)) x1_in = app_v.x;
            if (nb_ff == pcuw_pkg::CNT_W'(2)) v2_in = app_v;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcuw_pkg::ST_IDLE;
         bank_ff <= 1'b0;
         ovf_ff <= 1'b0;
         stage_ff <= pcuw_pkg::STG_LEFT;
         n_ff <= '0;
         nb_ff <= '0;
         j_ff <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff <= bank_in;
         ovf_ff <= ovf_in;
         stage_ff <= stage_in;
         n_ff <= n_in;
         nb_ff <= nb_in;
         j_ff <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      e_ff <= e_in;
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      v2_ff <= v2_in;
      if (md_req.start) begin
         neg_ff <= neg_in;
         base_ff <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) mem0[wr_addr] <= wr_v;
      if (wr_en && wr_bank) mem1[wr_addr] <= wr_v;
      if (rd_en) begin
         rd0_ff <= mem0[rd_addr];
         rd1_ff <= mem1[rd_addr];
      end
   end

   `PCUW_ASSERT(a_cnt_range, clock, reset, n_ff <= pcuw_pkg::CNT_W'(pcuw_pkg::DEPTH) && nb_ff <= pcuw_pkg::CNT_W'(pcuw_pkg::DEPTH))
   `PCUW_ASSERT(a_div_done, clock, reset, md_rsp.done |-> state_ff == pcuw_pkg::ST_DIV)
   `PCUW_NEVER(a_push_full, clock, reset, rsp_push && rsp_full)
   `PCUW_ASSERT(a_out_idle, clock, reset, rsp_push && rsp_data.last_out |=> state_ff == pcuw_pkg::ST_IDLE && n_ff == '0)
endmodule

[rtl/polygon_clip_to_unit_window_core.sv]
// Unit window polygon clipper. Vertex beats (signed Q8.16, last one marked)
// enter through a four deep queue at one per cycle unless it is full; up
// to 16 are kept per polygon and later ones only raise the overflow flag.
// On the marked vertex the clip engine runs the left, bottom, right and
// top stages in turn, and every edge crossing goes through the shared
// multiply and one-bit-per-cycle divider. Results leave through a two
// entry queue, which holds the engine while it is full; the next
// polygon's vertices queue up meanwhile.
// Depends on pcuw_pkg, pcuw_front, pcuw_back, pcuw_muldiv and pcuw_rspq.
module polygon_clip_to_unit_window_core (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  pcuw_pkg::req_type req_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output pcuw_pkg::rsp_type rsp_data
);
   logic deq_valid, deq_pop, q_push, q_full;
   pcuw_pkg::fitem_type deq_item;
   pcuw_pkg::rsp_type q_data;

   pcuw_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .deq_pop(deq_pop), .deq_valid(deq_valid),
      .deq_item(deq_item)
   );

   pcuw_back u_back (
      .clock(clock), .reset(reset), .deq_valid(deq_valid), .deq_item(deq_item),
      .deq_pop(deq_pop), .rsp_push(q_push), .rsp_full(q_full), .rsp_data(q_data)
   );

   pcuw_rspq u_rspq (
      .clock(clock), .reset(reset), .push(q_push), .full(q_full),
      .push_data(q_data), .pop(rsp_pop), .empty(rsp_empty), .pop_data(rsp_data)
   );
endmodule

[test/tb.sv]
// Self-checking testbench of the unit window polygon clipper.
// Depends on pcuw_pkg and polygon_clip_to_unit_window_core; it predicts the clipped
// vertices of each polygon and checks every result beat against that prediction.
module tb;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 60;
   localparam longint ONE = 65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   pcuw_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   pcuw_pkg::rsp_type rsp_data;

   pcuw_pkg::rsp_type clipped_q[$];
   int errors = 0;
   int vertices_sent = 0;
   int idle_cycles = 0;
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int pop_hold = 0;

   // Prediction state: the polygon being loaded and the work store of a stage.
   longint poly_x[pcuw_pkg::DEPTH];
   longint poly_y[pcuw_pkg::DEPTH];
   longint work_x[pcuw_pkg::DEPTH];
   longint work_y[pcuw_pkg::DEPTH];
   int poly_count = 0;
   int work_count = 0;
   bit poly_ovf = 1'b0;

   polygon_clip_to_unit_window_core u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit on_inner_side(logic [1:0] stage, longint x, longint y);
      case (stage)
         pcuw_pkg::STG_LEFT: return x >= -ONE;
         pcuw_pkg::STG_BOTTOM: return y >= -ONE;
         pcuw_pkg::STG_RIGHT: return x <= ONE;
         default: return y <= ONE;
      endcase
   endfunction

   task automatic work_append(longint x, longint y);
      if (work_count < pcuw_pkg::DEPTH) begin
         work_x[work_count] = x;
         work_y[work_count] = y;
         work_count++;
      end else begin
         poly_ovf = 1'b1;
      end
   endtask

   // The quotient of SystemVerilog division truncates toward zero, as the block does.
   task automatic append_crossing(logic [1:0] stage, longint sx, longint sy,
                                  longint ex, longint ey);
      longint b;
      longint q;
      b = (stage == pcuw_pkg::STG_LEFT || stage == pcuw_pkg::STG_BOTTOM) ? -ONE : ONE;
      if (stage == pcuw_pkg::STG_LEFT || stage == pcuw_pkg::STG_RIGHT) begin
         q = (ex == sx) ? 0 : ((b - sx) * (ey - sy)) / (ex - sx);
         work_append(b, sy + q);
      end else begin
         q = (ey == sy) ? 0 : ((b - sy) * (ex - sx)) / (ey - sy);
         work_append(sx + q, b);
      end
   endtask

   task automatic clip_one_stage(logic [1:0] stage);
      longint sx, sy, ex, ey;
      bit s_in;
      work_count = 0;
      if (poly_count > 0) begin
         sx = poly_x[poly_count-1];
         sy = poly_y[poly_count-1];
         for (int j = 0; j < poly_count; j++) begin
            ex = poly_x[j];
            ey = poly_y[j];
            s_in = on_inner_side(stage, sx, sy);
            if (on_inner_side(stage, ex, ey)) begin
               if (!s_in) append_crossing(stage, sx, sy, ex, ey);
               work_append(ex, ey);
            end else if (s_in) begin
               append_crossing(stage, sx, sy, ex, ey);
            end
            sx = ex;
            sy = ey;
         end
      end
      // A line that came back as three points is folded back into a line.
      if (poly_count == 2 && work_count == 3) begin
         poly_x[0] = work_x[0];
         poly_y[0] = work_y[0];
         if (work_x[0] == work_x[1]) begin
            poly_x[1] = work_x[2];
            poly_y[1] = work_y[2];
         end else begin
            poly_x[1] = work_x[1];
            poly_y[1] = work_y[1];
         end
      end else begin
         for (int j = 0; j < work_count; j++) begin
            poly_x[j] = work_x[j];
            poly_y[j] = work_y[j];
         end
         poly_count = work_count;
      end
   endtask

   task automatic predict_vertex(pcuw_pkg::req_type item);
      pcuw_pkg::rsp_type r;
      if (poly_count < pcuw_pkg::MAX_VERTICES) begin
         poly_x[poly_count] = longint'(item.vertex_x);
         poly_y[poly_count] = longint'(item.vertex_y);
         poly_count++;
      end else begin
         poly_ovf = 1'b1;
      end
      if (item.last_vertex) begin
         clip_one_stage(pcuw_pkg::STG_LEFT);
         clip_one_stage(pcuw_pkg::STG_BOTTOM);
         clip_one_stage(pcuw_pkg::STG_RIGHT);
         clip_one_stage(pcuw_pkg::STG_TOP);
         if (poly_count == 0) begin
            r = '0;
            r.last_out = 1'b1;
            r.empty_res = 1'b1;
            r.overflow = poly_ovf;
            clipped_q.push_back(r);
         end else begin
            for (int k = 0; k < poly_count; k++) begin
               r.out_x = poly_x[k][pcuw_pkg::CW-1:0];
               r.out_y = poly_y[k][pcuw_pkg::CW-1:0];
               r.last_out = (k + 1 == poly_count);
               r.empty_res = 1'b0;
               r.overflow = poly_ovf;
               clipped_q.push_back(r);
            end
         end
         poly_count = 0;
         poly_ovf = 1'b0;
      end
   endtask

   // Called and returning at a falling edge.
   task automatic send_vertex(longint x, longint y, bit last);
      pcuw_pkg::req_type item;
      int gap;
      item.vertex_x = x[pcuw_pkg::CW-1:0];
      item.vertex_y = y[pcuw_pkg::CW-1:0];
      item.last_vertex = last;
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      predict_vertex(item);
      vertices_sent++;
      @(negedge clock);
      gap = 0;
      if (sender_gaps && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_push <= 1'b0;
      while (clipped_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic longint pick_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return $urandom_range(0, 1) ? longint'(8388607) : longint'(-8388608);
         1: return (($urandom_range(0, 1)) ? ONE : -ONE) + $urandom_range(0, 2) - 1;
         8, 9: return longint'($signed(24'($urandom)));
         default: return longint'($urandom_range(0, 262144)) - 131072;
      endcase
   endfunction

   task automatic send_polygon(int n);
      for (int i = 0; i < n; i++)
         send_vertex(pick_coord(), pick_coord(), i == n - 1);
   endtask

   task automatic test_basic_shapes();
      send_vertex(0, 0, 1'b1);                         // single point inside
      send_vertex(3 * ONE, 0, 1'b1);                   // single point outside
      send_vertex(-ONE, -ONE, 1'b0);                   // square on the boundary
      send_vertex(ONE, -ONE, 1'b0);
      send_vertex(ONE, ONE, 1'b0);
      send_vertex(-ONE, ONE, 1'b1);
      send_vertex(-8388608, -8388608, 1'b0);           // extremes, crossing every edge
      send_vertex(8388607, -8388608, 1'b0);
      send_vertex(8388607, 8388607, 1'b0);
      send_vertex(-8388608, 8388607, 1'b1);
   endtask

   task automatic test_lines();
      send_vertex(-2 * ONE, 0, 1'b0);                  // near-horizontal line across the window
      send_vertex(2 * ONE, ONE / 3, 1'b1);
      send_vertex(0, -3 * ONE, 1'b0);                  // near-vertical line across the window
      send_vertex(ONE / 2, 3 * ONE, 1'b1);
      send_vertex(5 * ONE, 5 * ONE, 1'b0);             // line entirely outside
      send_vertex(6 * ONE, 4 * ONE, 1'b1);
   endtask

   task automatic test_overflow();
      // Twenty vertices: the last four are dropped and flagged.
      for (int i = 0; i < 20; i++)
         send_vertex((i % 2) ? 2 * ONE : -2 * ONE, (i - 10) * ONE / 4, i == 19);
      wait_for_results();
   endtask

   task automatic test_random_polygons();
      int n;
      int r;
      while (vertices_sent < 410) begin
         r = $urandom_range(0, 19);
         if (r == 0) n = $urandom_range(17, 20);
         else if (r < 4) n = $urandom_range(7, 16);
         else if (r < 6) n = 2;
         else n = $urandom_range(1, 6);
         if (vertices_sent > 200 && vertices_sent < 260) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end else begin
            sender_gaps = 1'b1;
            receiver_gaps = 1'b1;
         end
         send_polygon(n);
      end
   endtask

   always @(negedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (receiver_gaps && $urandom_range(0, 3) == 0)
            pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if (!reset && !rsp_empty && rsp_pop) begin
         if (clipped_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_data);
            errors++;
         end else begin
            if (rsp_data.out_x !== clipped_q[0].out_x) begin
               $display("%0t: out_x expected %0d got %0d", $time,
                        clipped_q[0].out_x, rsp_data.out_x);
               errors++;
            end
            if (rsp_data.out_y !== clipped_q[0].out_y) begin
               $display("%0t: out_y expected %0d got %0d", $time,
                        clipped_q[0].out_y, rsp_data.out_y);
               errors++;
            end
            if (rsp_data.last_out !== clipped_q[0].last_out) begin
               $display("%0t: last_out expected %b got %b", $time,
                        clipped_q[0].last_out, rsp_data.last_out);
               errors++;
            end
            if (rsp_data.empty_res !== clipped_q[0].empty_res) begin
               $display("%0t: empty_res expected %b got %b", $time,
                        clipped_q[0].empty_res, rsp_data.empty_res);
               errors++;
            end
            if (rsp_data.overflow !== clipped_q[0].overflow) begin
               $display("%0t: overflow expected %b got %b", $time,
                        clipped_q[0].overflow, rsp_data.overflow);
               errors++;
            end
            void'(clipped_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[polygon_clip_to_unit_window_core] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_shapes();
      test_lines();
      test_overflow();
      test_random_polygons();
      wait_for_results();
      if (errors == 0)
         $display("[polygon_clip_to_unit_window_core] OK");
      else
         $display("[polygon_clip_to_unit_window_core] ERROR");
      $finish;
   end
endmodule

[polygon_clip_to_unit_window_core.f]
+incdir+rtl
rtl/pcuw_pkg.sv
rtl/pcuw_front.sv
rtl/pcuw_muldiv.sv
rtl/pcuw_rspq.sv
rtl/pcuw_back.sv
rtl/polygon_clip_to_unit_window_core.sv
test/tb.sv
